// ===== hw/rtl/priority_task_scheduler_with_delays_core_macros.svh =====
// Assertion macros for the task scheduler checker.
// Depends on nothing; included by the checker file.
`ifndef PRIORITY_TASK_SCHEDULER_WITH_DELAYS_CORE_MACROS_SVH
`define PRIORITY_TASK_SCHEDULER_WITH_DELAYS_CORE_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define PTS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication outside reset.
`define PTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hw/rtl/pts_pkg.sv =====
// Shared types and constants for the task scheduler.
// No dependencies.
package pts_pkg;
    localparam int TASK_SLOTS = 8;
    localparam int SLOT_W = $clog2(TASK_SLOTS);
    localparam int LINK_W = $clog2(TASK_SLOTS + 1);
    localparam logic [LINK_W-1:0] END_MARK = LINK_W'(TASK_SLOTS);
    localparam logic [7:0] IDLE_PRIORITY = 8'd255;

    localparam logic [1:0] KIND_CREATE = 2'd0;
    localparam logic [1:0] KIND_START  = 2'd1;
    localparam logic [1:0] KIND_DELAY  = 2'd2;
    localparam logic [1:0] KIND_TICK   = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_IDLE = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  task_priority;
        logic [15:0] delay_ticks;
    } in_word_t;

    typedef struct packed {
        logic [2:0]  running_task;
        logic        running_valid;
        logic        switched;
        logic [15:0] switch_count;
        logic [15:0] tick_count;
        logic [1:0]  status;
    } out_word_t;

    // Controller commands to the datapath
    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,       // latch input word
        CMD_CREATE,     // allocate slot, start ready insert
        CMD_RINS_STEP,  // one step of ready list walk
        CMD_START,
        CMD_DELAY,      // unlink ready head, start delay insert
        CMD_DINS_STEP,  // one step of delay list walk
        CMD_TICK,       // decrement head delta
        CMD_REL_STEP,   // release one zero-delta head
        CMD_SCHED,      // dispatch ready head, build result
        CMD_DONE
    } cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       full;
        logic       delay_ok;
        logic       delay_idle;
        logic       rins_done;
        logic       dins_done;
        logic       rel_more;
    } stat_t;
endpackage

// ===== hw/rtl/pts_if.sv =====
// Valid/ready channel carrying one word of type word_t.
// Depends on nothing outside its parameter.
interface pts_if #(parameter type word_t = logic) ();
    logic  valid;
    logic  ready;
    word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/pts_ctrl.sv =====
// Sequencer for the task scheduler: walks the list operations step by step.
// Depends on pts_pkg.
module pts_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    input  pts_pkg::stat_t stat,
    output pts_pkg::cmd_t  cmd
);
    import pts_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_DISP, S_RINS, S_DINS, S_REL, S_SCHED, S_OUT} state_t;
    state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;

    // Next state and command
    always_comb
    begin
        state_next = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd = CMD_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd = CMD_LOAD;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                state_next = S_SCHED;
                case (stat.kind)
                    KIND_CREATE:
                    begin
                        if (!stat.full)
                        begin
                            cmd = CMD_CREATE;
                            state_next = S_RINS;
                        end
                        else
                        begin
                            state_next = S_OUT;
                        end
                    end
                    KIND_START: cmd = CMD_START;
                    KIND_DELAY:
                    begin
                        if (stat.delay_ok && !stat.delay_idle)
                        begin
                            cmd = CMD_DELAY;
                            state_next = S_DINS;
                        end
                        else
                        begin
                            state_next = S_OUT;
                        end
                    end
                    default:
                    begin
                        cmd = CMD_TICK;
                        state_next = S_REL;
                    end
                endcase
            end
            S_RINS:
            begin
                cmd = CMD_RINS_STEP;
                if (stat.rins_done)
                begin
                    state_next = stat.rel_more || stat.kind == KIND_TICK ? S_REL : S_SCHED;
                end
            end
            S_DINS:
            begin
                cmd = CMD_DINS_STEP;
                if (stat.dins_done)
                begin
                    state_next = S_SCHED;
                end
            end
            S_REL:
            begin
                if (stat.rel_more)
                begin
                    cmd = CMD_REL_STEP;
                    state_next = S_RINS;
                end
                else
                begin
                    state_next = S_SCHED;
                end
            end
            S_SCHED:
            begin
                cmd = CMD_SCHED;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                cmd = CMD_DONE;
                out_valid_next = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end
endmodule

// ===== hw/rtl/pts_dp.sv =====
// Datapath for the task scheduler: slot tables, list walkers, counters.
// Depends on pts_pkg.
module pts_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  pts_pkg::in_word_t   in_word,
    input  pts_pkg::cmd_t       cmd,
    output pts_pkg::stat_t      stat,
    output pts_pkg::out_word_t  out_word
);
    import pts_pkg::*;

    logic [7:0]        prio_reg  [TASK_SLOTS];
    logic [LINK_W-1:0] rlink_reg [TASK_SLOTS];
    logic [15:0]       delta_reg [TASK_SLOTS];
    logic [LINK_W-1:0] dlink_reg [TASK_SLOTS];
    logic [LINK_W-1:0] rfirst_reg, dfirst_reg, used_reg;
    logic [SLOT_W-1:0] cur_reg;
    logic              cur_valid_reg, started_reg;
    logic [15:0]       ticks_reg, switches_reg;
    in_word_t          word_reg;
    // walker state
    logic [SLOT_W-1:0] ins_reg;   // slot being inserted
    logic [LINK_W-1:0] walk_reg;  // predecessor, END_MARK means at list head
    logic [15:0]       d_reg;     // remaining delay during delay insert
    logic              done_reg;
    logic              sw_reg;
    logic [1:0]        status_reg;
    logic [1:0]        status_next;
    logic              disp_reg;

    logic [LINK_W-1:0] nxt;
    logic [SLOT_W-1:0] nxt_s, walk_s, rf_s, df_s;
    logic              nxt_valid;
    logic              go_here;

    assign rf_s = rfirst_reg[SLOT_W-1:0];
    assign df_s = dfirst_reg[SLOT_W-1:0];
    assign walk_s = walk_reg[SLOT_W-1:0];

    // Candidate successor of current walk position (ready or delay list)
    always_comb
    begin
        if (walk_reg == END_MARK)
        begin
            nxt = (cmd == CMD_DINS_STEP) ? dfirst_reg : rfirst_reg;
        end
        else
        begin
            nxt = (cmd == CMD_DINS_STEP) ? dlink_reg[walk_s] : rlink_reg[walk_s];
        end
        nxt_valid = nxt < END_MARK;
        nxt_s = nxt[SLOT_W-1:0];
        if (cmd == CMD_DINS_STEP)
        begin
            go_here = !nxt_valid ||
                      (walk_reg == END_MARK ? d_reg <= delta_reg[nxt_s]
                                            : delta_reg[nxt_s] >= d_reg);
        end
        else
        begin
            go_here = !nxt_valid ||
                      (walk_reg == END_MARK ? prio_reg[nxt_s] > prio_reg[ins_reg]
                                            : prio_reg[nxt_s] > prio_reg[ins_reg]);
        end
    end

    always_comb
    begin
        stat.kind       = word_reg.kind;
        stat.full       = used_reg >= END_MARK;
        stat.delay_ok   = cur_valid_reg && rfirst_reg < END_MARK;
        stat.delay_idle = rfirst_reg == '0;
        stat.rins_done  = done_reg || (cmd == CMD_RINS_STEP && go_here);
        stat.dins_done  = cmd == CMD_DINS_STEP && go_here;
        stat.rel_more   = dfirst_reg < END_MARK && delta_reg[df_s] == '0;
    end

    assign out_word.running_task  = cur_valid_reg ? 3'(cur_reg) : 3'd0;
    assign out_word.running_valid = cur_valid_reg;
    assign out_word.switched      = sw_reg;
    assign out_word.switch_count  = switches_reg;
    assign out_word.tick_count    = ticks_reg;
    assign out_word.status        = status_reg;

    // Payload tables and walk state
    always_ff @(posedge clk)
    begin
        case (cmd)
            CMD_LOAD:
            begin
                word_reg <= in_word;
                sw_reg <= 1'b0;
                done_reg <= 1'b0;
            end
            CMD_CREATE:
            begin
                ins_reg <= used_reg[SLOT_W-1:0];
                walk_reg <= END_MARK;
                done_reg <= 1'b0;
            end
            CMD_DELAY:
            begin
                ins_reg <= rf_s;
                walk_reg <= END_MARK;
                d_reg <= (word_reg.delay_ticks == '0) ? 16'd1 : word_reg.delay_ticks;
            end
            CMD_RINS_STEP:
            begin
                if (!done_reg && !go_here)
                begin
                    walk_reg <= nxt;
                end
                done_reg <= 1'b0;
            end
            CMD_DINS_STEP:
            begin
                if (go_here)
                begin
                    delta_reg[ins_reg] <= d_reg;
                    dlink_reg[ins_reg] <= nxt;
                    if (walk_reg != END_MARK)
                    begin
                        dlink_reg[walk_s] <= LINK_W'(ins_reg);
                    end
                    if (nxt_valid)
                    begin
                        delta_reg[nxt_s] <= delta_reg[nxt_s] - d_reg;
                    end
                end
                else
                begin
                    d_reg <= d_reg - delta_reg[nxt_s];
                    walk_reg <= nxt;
                end
            end
            CMD_TICK:
            begin
                if (dfirst_reg < END_MARK && delta_reg[df_s] != '0)
                begin
                    delta_reg[df_s] <= delta_reg[df_s] - 16'd1;
                end
            end
            CMD_REL_STEP:
            begin
                dlink_reg[df_s] <= END_MARK;
                ins_reg <= df_s;
                walk_reg <= END_MARK;
                done_reg <= 1'b0;
            end
            CMD_SCHED:
            begin
                if (started_reg && rfirst_reg < END_MARK)
                begin
                    sw_reg <= !cur_valid_reg || cur_reg != rf_s;
                end
            end
            default: ;
        endcase
        // status is fixed in the dispatch cycle
        if (disp_reg)
        begin
            status_reg <= status_next;
        end
    end

    // Control state, ready list and priorities with reset values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TASK_SLOTS; i++)
            begin
                prio_reg[i]  <= (i == 0) ? IDLE_PRIORITY : 8'd0;
                rlink_reg[i] <= END_MARK;
            end
            rfirst_reg    <= '0;
            dfirst_reg    <= END_MARK;
            used_reg      <= LINK_W'(1);
            cur_reg       <= '0;
            cur_valid_reg <= 1'b0;
            started_reg   <= 1'b0;
            ticks_reg     <= '0;
            switches_reg  <= '0;
        end
        else
        begin
            case (cmd)
                CMD_CREATE:
                begin
                    prio_reg[used_reg[SLOT_W-1:0]] <= word_reg.task_priority;
                    used_reg <= used_reg + LINK_W'(1);
                end
                CMD_START: started_reg <= 1'b1;
                CMD_TICK: ticks_reg <= ticks_reg + 16'd1;
                CMD_DELAY: rfirst_reg <= rlink_reg[rf_s];
                CMD_RINS_STEP:
                begin
                    if (!done_reg && go_here)
                    begin
                        rlink_reg[ins_reg] <= nxt;
                        if (walk_reg == END_MARK)
                        begin
                            rfirst_reg <= LINK_W'(ins_reg);
                        end
                        else
                        begin
                            rlink_reg[walk_s] <= LINK_W'(ins_reg);
                        end
                    end
                end
                CMD_DINS_STEP:
                begin
                    if (go_here && walk_reg == END_MARK)
                    begin
                        dfirst_reg <= LINK_W'(ins_reg);
                    end
                end
                CMD_REL_STEP: dfirst_reg <= dlink_reg[df_s];
                CMD_SCHED:
                begin
                    if (started_reg && rfirst_reg < END_MARK)
                    begin
                        if (cur_valid_reg && cur_reg != rf_s)
                        begin
                            switches_reg <= switches_reg + 16'd1;
                        end
                        cur_reg <= rf_s;
                        cur_valid_reg <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Status code, set in the dispatch cycle
    always_comb
    begin
        status_next = ST_OK;
        if (word_reg.kind == KIND_CREATE && stat.full)
        begin
            status_next = ST_FULL;
        end
        else if (word_reg.kind == KIND_DELAY && stat.delay_ok && stat.delay_idle)
        begin
            status_next = ST_IDLE;
        end
    end

    // Marks the cycle after a word is loaded
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            disp_reg <= 1'b0;
        end
        else
        begin
            disp_reg <= cmd == CMD_LOAD;
        end
    end
endmodule

// ===== hw/rtl/priority_task_scheduler_with_delays_core.sv =====
// Top level of the priority task scheduler with delay list.
// Depends on pts_pkg, pts_if, pts_ctrl and pts_dp.
// One word in, one result word out; the next word is taken only after the
// result has been taken. A refused create, a refused delay or a delay before
// start goes straight from dispatch to the result; every other word ends by
// dispatching the ready head. A create inserts the new task by walking the
// ready list; a delay unlinks the ready head and inserts it by walking the
// delay list; a tick decrements the delay-list head delta and then releases
// each zero-delta head: the unlink and its ready-list walk. One list entry is
// visited per cycle. The result is held until it is taken, and the next word
// can be accepted in the cycle after the result is taken.
module priority_task_scheduler_with_delays_core (
    input  logic  clk,
    input  logic  rst_n,
    pts_if.sink   in_ch,
    pts_if.source out_ch
);
    import pts_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    pts_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_ready(in_ch.ready),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready),
        .stat(stat), .cmd(cmd)
    );

    pts_dp u_dp (
        .clk(clk), .rst_n(rst_n),
        .in_word(in_ch.data), .cmd(cmd), .stat(stat), .out_word(out_ch.data)
    );
endmodule

// ===== hw/rtl/pts_checker.sv =====
// Port-level checker for the task scheduler, bound to the top level.
// Depends on pts_pkg and the macros header.
`include "priority_task_scheduler_with_delays_core_macros.svh"
module pts_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input pts_pkg::out_word_t out_word
);
    import pts_pkg::*;

    logic stalled;
    logic idle_word;
    logic idle_clean;

    // Terms for the checks below
    assign stalled    = out_valid && !out_ready;
    assign idle_word  = out_valid && !out_word.running_valid;
    assign idle_clean = out_word.running_task == 3'd0 && !out_word.switched;

    `PTS_ASSERT_IMP(a_no_accept_while_full, clk, rst_n, out_valid, !in_ready)
    `PTS_ASSERT_NEXT(a_out_holds, clk, rst_n, stalled, out_valid && $stable(out_word))
    `PTS_ASSERT_IMP(a_task_zero_when_idle, clk, rst_n, idle_word, idle_clean)
    `PTS_ASSERT_IMP(a_status_code, clk, rst_n, out_valid, out_word.status <= ST_IDLE)
endmodule

bind priority_task_scheduler_with_delays_core pts_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_word(out_ch.data)
);
